### hw/rtl/bea_pkg.sv
// ----------------------------------------------------------------------------
// bea_pkg: shared types and constants for the bitmap entry allocator
// Sizes of the bitmap, field widths, status and kind codes, and the
// structs passed between the sequencer, the bitmap RAM and the row scanner.
// ----------------------------------------------------------------------------
package bea_pkg;

    // Bitmap geometry: one RAM row holds eight entries
    localparam int ENTRIES  = 256;
    localparam int ROW_BITS = 8;
    localparam int BIT_W    = $clog2(ROW_BITS);
    localparam int ROWS     = ENTRIES / ROW_BITS;
    localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ENT_W    = ROW_W + BIT_W;

    // Field widths of the request and result
    localparam int IDX_W    = 9;
    localparam int USABLE_W = 9;
    localparam int STAT_W   = 2;
    localparam int GRANT_W  = 8;
    localparam int CNT_W    = 9;

    // Width used for limit and range compares
    localparam int CMP_W = (ENT_W + 1 > USABLE_W) ? ENT_W + 1 : USABLE_W;

    // Stream payload widths
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;

    localparam logic [USABLE_W-1:0] USABLE_RST = USABLE_W'(256);

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FREE,
        ST_DONE
    } t_state;

    // Access to the bitmap RAM
    typedef struct packed {
        logic                rd_en;
        logic [ROW_W-1:0]    rd_row;
        logic                wr_en;
        logic [ROW_W-1:0]    wr_row;
        logic [ROW_BITS-1:0] wr_data;
    } t_ram_req;

    // Outcome of checking one row for a free entry
    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] bit_pos;
        logic             last;
    } t_scan_res;

endpackage

### hw/rtl/bitmap_entry_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_entry_allocator: first-fit allocator over a 256-entry bitmap
// Allocate requests take the lowest free entry below the usable limit,
// free requests release a named entry; each request returns one result.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake           Payload
// s         in   i_s_tvalid/o_s_tready  tuser: kind; tdata: entry_index
// m         out  o_m_tvalid/i_m_tready  tdata: status, granted_index, used_count
// cfg       in   i_cfg_we (no wait)     i_cfg_wdata: usable_entries
//
// An allocate scans the bitmap reading one eight-entry row per cycle from
// the RAM read port and stops at the first free entry or at the last row
// below the limit. A free reads its row, writes it back modified and then
// returns its result; an out-of-range free goes straight to the result.
// The bitmap reads as all free right after reset; no clearing pass.
// A result waits in the output register while the next request is taken;
// a new result stalls in the sequencer until that register is taken.
// ----------------------------------------------------------------------------
module bitmap_entry_allocator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [bea_pkg::S_DATA_W-1:0]     i_s_tdata,   // [8:0] entry_index
    input  logic                             i_s_tuser,   // [0] kind
    // result stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [bea_pkg::M_DATA_W-1:0]     o_m_tdata,   // [1:0] status,
                                                          // [9:2] granted_index,
                                                          // [18:10] used_count
    // usable_entries register
    input  logic                             i_cfg_we,
    input  logic [bea_pkg::USABLE_W-1:0]     i_cfg_wdata
);

    bea_pkg::t_ram_req            ram_req;
    bea_pkg::t_scan_res           scan_res;
    logic [bea_pkg::ROW_BITS-1:0] rd_data;
    logic [bea_pkg::ROW_W-1:0]    scan_row;
    logic [bea_pkg::USABLE_W-1:0] usable;

    // Sequencer
    bea_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_s_tvalid),
        .o_req_ready   (o_s_tready),
        .i_kind        (i_s_tuser),
        .i_entry_index (i_s_tdata[bea_pkg::IDX_W-1:0]),
        .o_res_valid   (o_m_tvalid),
        .i_res_ready   (i_m_tready),
        .o_res_data    (o_m_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_ram_req     (ram_req),
        .i_rd_data     (rd_data),
        .o_scan_row    (scan_row),
        .o_usable      (usable),
        .i_scan        (scan_res)
    );

    // Bitmap storage
    bea_map_ram u_map_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

    // Find-first-free unit
    bea_row_scan u_row_scan (
        .i_row_data (rd_data),
        .i_row      (scan_row),
        .i_usable   (usable),
        .o_res      (scan_res)
    );

endmodule

### hw/rtl/bea_map_ram.sv
// ----------------------------------------------------------------------------
// bea_map_ram: allocation bitmap storage
// One row of eight entries written and one row read per cycle, read data
// registered. Per-row valid bits cleared at reset make every row read as
// all free until it is first written.
// ----------------------------------------------------------------------------
module bea_map_ram (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bea_pkg::t_ram_req                i_req,
    output logic [bea_pkg::ROW_BITS-1:0]     o_rd_data
);

    logic [bea_pkg::ROW_BITS-1:0] r_mem [bea_pkg::ROWS];
    logic [bea_pkg::ROWS-1:0]     r_vld;
    logic [bea_pkg::ROW_BITS-1:0] r_rd_data;
    logic                         r_rd_vld;

    // Write row contents, read row registered
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_row] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_row];
        end
    end

    // Track which rows hold written data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.wr_row] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_vld[i_req.rd_row];
            end
        end
    end

    // Unwritten rows read as all free
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

### hw/rtl/bea_row_scan.sv
// ----------------------------------------------------------------------------
// bea_row_scan: find-first-free unit for one bitmap row
// Masks entries at or above the usable limit, finds the lowest free entry
// in the row and flags the row as the last one worth scanning.
// ----------------------------------------------------------------------------
module bea_row_scan (
    input  logic [bea_pkg::ROW_BITS-1:0] i_row_data,
    input  logic [bea_pkg::ROW_W-1:0]    i_row,
    input  logic [bea_pkg::USABLE_W-1:0] i_usable,
    output bea_pkg::t_scan_res           o_res
);

    logic [bea_pkg::CMP_W-1:0]    eff_limit;
    logic [bea_pkg::CMP_W-1:0]    row_base;
    logic [bea_pkg::ROW_BITS-1:0] usable_mask;
    logic [bea_pkg::ROW_BITS-1:0] free_bits;
    logic [bea_pkg::BIT_W-1:0]    first_pos;

    // Clamp the limit to the bitmap size
    always_comb begin
        if (bea_pkg::CMP_W'(i_usable) > bea_pkg::CMP_W'(bea_pkg::ENTRIES)) begin
            eff_limit = bea_pkg::CMP_W'(bea_pkg::ENTRIES);
        end else begin
            eff_limit = bea_pkg::CMP_W'(i_usable);
        end
    end

    assign row_base = bea_pkg::CMP_W'(i_row) << bea_pkg::BIT_W;

    // Mark entries of this row that lie below the limit
    always_comb begin
        for (int b = 0; b < bea_pkg::ROW_BITS; b++) begin
            usable_mask[b] = (row_base + bea_pkg::CMP_W'(b)) < eff_limit;
        end
    end

    assign free_bits = ~i_row_data & usable_mask;

    // Lowest free entry wins
    always_comb begin
        first_pos = '0;
        for (int b = bea_pkg::ROW_BITS - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                first_pos = bea_pkg::BIT_W'(b);
            end
        end
    end

    assign o_res.found   = |free_bits;
    assign o_res.bit_pos = first_pos;
    assign o_res.last    = (i_row == bea_pkg::ROW_W'(bea_pkg::ROWS - 1))
                        || ((row_base + bea_pkg::CMP_W'(bea_pkg::ROW_BITS)) >= eff_limit);

endmodule

### hw/rtl/bea_seq.sv
// ----------------------------------------------------------------------------
// bea_seq: request sequencer of the bitmap entry allocator
// Walks the bitmap one row per cycle for an allocate, does a read-modify-
// write of one row for a free, keeps the used count and the usable limit,
// and holds the result in an output register.
// ----------------------------------------------------------------------------
module bea_seq (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request side
    input  logic                             i_req_valid,
    output logic                             o_req_ready,
    input  logic                             i_kind,
    input  logic [bea_pkg::IDX_W-1:0]        i_entry_index,
    // result side
    output logic                             o_res_valid,
    input  logic                             i_res_ready,
    output logic [bea_pkg::M_DATA_W-1:0]     o_res_data,
    // limit register
    input  logic                             i_cfg_we,
    input  logic [bea_pkg::USABLE_W-1:0]     i_cfg_wdata,
    // bitmap RAM and row scanner
    output bea_pkg::t_ram_req                o_ram_req,
    input  logic [bea_pkg::ROW_BITS-1:0]     i_rd_data,
    output logic [bea_pkg::ROW_W-1:0]        o_scan_row,
    output logic [bea_pkg::USABLE_W-1:0]     o_usable,
    input  bea_pkg::t_scan_res               i_scan
);

    bea_pkg::t_state              r_state, n_state;
    logic [bea_pkg::ROW_W-1:0]    r_row;
    logic [bea_pkg::BIT_W-1:0]    r_bit;
    bea_pkg::t_status             r_status;
    logic [bea_pkg::GRANT_W-1:0]  r_grant;
    logic [bea_pkg::CNT_W-1:0]    r_used;
    logic [bea_pkg::USABLE_W-1:0] r_usable;
    logic                         r_res_valid;
    logic [bea_pkg::M_DATA_W-1:0] r_res_data;

    logic                         accept;
    logic                         out_free;
    logic                         out_of_range;
    logic [bea_pkg::ROW_W-1:0]    idx_row;
    logic [bea_pkg::ROW_BITS-1:0] scan_set;
    logic [bea_pkg::ROW_BITS-1:0] free_clr;
    logic                         free_hit;

    assign accept       = i_req_valid && o_req_ready;
    assign out_free     = !r_res_valid || i_res_ready;
    assign out_of_range = bea_pkg::CMP_W'(i_entry_index) >= bea_pkg::CMP_W'(bea_pkg::ENTRIES);
    assign idx_row      = bea_pkg::ROW_W'(i_entry_index >> bea_pkg::BIT_W);
    assign scan_set     = bea_pkg::ROW_BITS'(1) << i_scan.bit_pos;
    assign free_clr     = bea_pkg::ROW_BITS'(1) << r_bit;
    assign free_hit     = i_rd_data[r_bit];

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bea_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_kind == bea_pkg::KIND_ALLOC) begin
                        n_state = bea_pkg::ST_SCAN;
                    end else if (out_of_range) begin
                        n_state = bea_pkg::ST_DONE;
                    end else begin
                        n_state = bea_pkg::ST_FREE;
                    end
                end
            end
            bea_pkg::ST_SCAN: begin
                if (i_scan.found || i_scan.last) begin
                    n_state = bea_pkg::ST_DONE;
                end
            end
            bea_pkg::ST_FREE: begin
                n_state = bea_pkg::ST_DONE;
            end
            bea_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = bea_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bea_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs: handshake and RAM access per state
    always_comb begin
        o_req_ready       = 1'b0;
        o_ram_req.rd_en   = 1'b0;
        o_ram_req.rd_row  = '0;
        o_ram_req.wr_en   = 1'b0;
        o_ram_req.wr_row  = r_row;
        o_ram_req.wr_data = i_rd_data;
        unique case (r_state)
            bea_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_ram_req.rd_en  = 1'b1;
                    o_ram_req.rd_row = (i_kind == bea_pkg::KIND_FREE) ? idx_row : '0;
                end
            end
            bea_pkg::ST_SCAN: begin
                // prefetch the next row while checking this one
                o_ram_req.rd_en   = 1'b1;
                o_ram_req.rd_row  = r_row + bea_pkg::ROW_W'(1);
                o_ram_req.wr_en   = i_scan.found;
                o_ram_req.wr_data = i_rd_data | scan_set;
            end
            bea_pkg::ST_FREE: begin
                o_ram_req.wr_en   = free_hit;
                o_ram_req.wr_data = i_rd_data & ~free_clr;
            end
            bea_pkg::ST_DONE: begin
                o_req_ready = 1'b0;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

    // Control registers: state, count, limit, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bea_pkg::ST_IDLE;
            r_used      <= '0;
            r_usable    <= bea_pkg::USABLE_RST;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_usable <= i_cfg_wdata;
            end
            if (r_state == bea_pkg::ST_SCAN && i_scan.found) begin
                r_used <= r_used + bea_pkg::CNT_W'(1);
            end else if (r_state == bea_pkg::ST_FREE && free_hit) begin
                r_used <= r_used - bea_pkg::CNT_W'(1);
            end
            if (r_state == bea_pkg::ST_DONE && out_free) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // Working registers of the current request and the result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_row    <= (i_kind == bea_pkg::KIND_FREE) ? idx_row : '0;
            r_bit    <= i_entry_index[bea_pkg::BIT_W-1:0];
            r_status <= (i_kind == bea_pkg::KIND_FREE && out_of_range)
                      ? bea_pkg::STAT_RANGE : bea_pkg::STAT_OK;
            r_grant  <= '0;
        end else if (r_state == bea_pkg::ST_SCAN) begin
            if (i_scan.found) begin
                r_grant <= bea_pkg::GRANT_W'({r_row, i_scan.bit_pos});
            end else if (i_scan.last) begin
                r_status <= bea_pkg::STAT_FULL;
            end
            r_row <= r_row + bea_pkg::ROW_W'(1);
        end
        if (r_state == bea_pkg::ST_DONE && out_free) begin
            r_res_data <= bea_pkg::M_DATA_W'({r_used, r_grant, r_status});
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res_data  = r_res_data;
    assign o_scan_row  = r_row;
    assign o_usable    = r_usable;

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for bitmap_entry_allocator
// Drives allocate and free requests over the request stream, predicts each
// result with a local first-fit bitmap, and compares status, granted index
// and used count. Runs directed cases, then random phases under several
// usable limits and idling profiles, including one long output hold-off.
// ----------------------------------------------------------------------------

// Predicted allocator state plus the results still owed by the block
class alloc_scoreboard;

    typedef struct packed {
        bea_pkg::t_status                 status;
        logic [bea_pkg::GRANT_W-1:0]      granted;
        logic [bea_pkg::CNT_W-1:0]        count;
    } t_alloc_result;

    bit            used_map [bea_pkg::ENTRIES];
    int unsigned   used_total;
    int unsigned   usable_limit;
    t_alloc_result pending_results [$];
    int unsigned   errors;

    function new();
        foreach (used_map[i]) used_map[i] = 1'b0;
        used_total   = 0;
        usable_limit = bea_pkg::USABLE_RST;
        errors       = 0;
    endfunction

    // Apply one accepted request to the bitmap and queue its result
    function void note_request(bea_pkg::t_kind kind, logic [bea_pkg::IDX_W-1:0] idx);
        t_alloc_result r;
        int unsigned   limit;
        int unsigned   pos;
        r.status  = bea_pkg::STAT_OK;
        r.granted = '0;
        if (kind == bea_pkg::KIND_ALLOC) begin
            limit = (usable_limit > bea_pkg::ENTRIES) ? bea_pkg::ENTRIES : usable_limit;
            pos = 0;
            while (pos < limit && used_map[pos]) pos++;
            if (pos < limit) begin
                used_map[pos] = 1'b1;
                used_total++;
                r.granted = bea_pkg::GRANT_W'(pos);
            end else begin
                r.status = bea_pkg::STAT_FULL;
            end
        end else if (idx >= bea_pkg::ENTRIES) begin
            r.status = bea_pkg::STAT_RANGE;
        end else if (used_map[idx]) begin
            used_map[idx] = 1'b0;
            used_total--;
        end
        r.count = bea_pkg::CNT_W'(used_total);
        pending_results.push_back(r);
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(logic [bea_pkg::M_DATA_W-1:0] data);
        t_alloc_result exp_r;
        if (pending_results.size() == 0) begin
            $error("unexpected result: tdata %h", data);
            errors++;
            return;
        end
        exp_r = pending_results.pop_front();
        if (data[1:0] !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, data[1:0]);
            errors++;
        end
        if (data[9:2] !== exp_r.granted) begin
            $error("granted_index: expected %0d, got %0d", exp_r.granted, data[9:2]);
            errors++;
        end
        if (data[18:10] !== exp_r.count) begin
            $error("used_count: expected %0d, got %0d", exp_r.count, data[18:10]);
            errors++;
        end
    endfunction

endclass

module testbench;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 40;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_s_tvalid  = 1'b0;
    logic                           o_s_tready;
    logic [bea_pkg::S_DATA_W-1:0]   i_s_tdata   = '0;
    logic                           i_s_tuser   = 1'b0;
    logic                           o_m_tvalid;
    logic                           i_m_tready  = 1'b0;
    logic [bea_pkg::M_DATA_W-1:0]   o_m_tdata;
    logic                           i_cfg_we    = 1'b0;
    logic [bea_pkg::USABLE_W-1:0]   i_cfg_wdata = '0;

    alloc_scoreboard sb = new();

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_request   = 1'b0;
    int unsigned hold_left      = 0;
    int unsigned quiet_cycles   = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    bitmap_entry_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Take results, check them, and stall the output at random or on a hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_result(o_m_tdata);
        end
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // End the run when nothing moves on either stream for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[bitmap_entry_allocator] ERROR");
                $finish;
            end
        end
    end

    // Offer one request, idling first at random; return at the accepting edge
    task automatic send_request(input bea_pkg::t_kind kind,
                                input logic [bea_pkg::IDX_W-1:0] idx);
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= bea_pkg::S_DATA_W'(idx);
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_request(kind, idx);
    endtask

    // Drop the request stream and wait until every result has come back
    task automatic settle();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input int unsigned value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= bea_pkg::USABLE_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.usable_limit = value;
    endtask

    // One random phase: set the limit and idling, then stream requests
    task automatic run_phase(input int unsigned limit, input int unsigned alloc_pct,
                             input int unsigned items, input int unsigned idle_pct,
                             input int unsigned stall_pct, input bit pressure);
        bea_pkg::t_kind             kind;
        logic [bea_pkg::IDX_W-1:0]  idx;
        int unsigned                sel;
        int unsigned                start;
        int unsigned                step;
        settle();
        write_limit(limit);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        if (pressure) hold_request = 1'b1;
        repeat (items) begin
            idx = bea_pkg::IDX_W'($urandom_range(511));
            if ($urandom_range(99) < alloc_pct) begin
                kind = bea_pkg::KIND_ALLOC;
            end else begin
                kind = bea_pkg::KIND_FREE;
                sel  = $urandom_range(99);
                if (sel < 60 && sb.used_total > 0) begin
                    // free an entry that is in use, searching from a random spot
                    start = $urandom_range(bea_pkg::ENTRIES - 1);
                    step  = 0;
                    while (!sb.used_map[(start + step) % bea_pkg::ENTRIES]) step++;
                    idx = bea_pkg::IDX_W'((start + step) % bea_pkg::ENTRIES);
                end else if (sel < 88) begin
                    idx = bea_pkg::IDX_W'($urandom_range(bea_pkg::ENTRIES - 1));
                end
            end
            send_request(kind, idx);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: first-fit order, double free, range errors, limit extremes
        write_limit(256);
        send_request(bea_pkg::KIND_ALLOC, 9'd0);
        send_request(bea_pkg::KIND_ALLOC, 9'd511);
        send_request(bea_pkg::KIND_ALLOC, 9'h155);
        send_request(bea_pkg::KIND_FREE,  9'd1);
        send_request(bea_pkg::KIND_FREE,  9'd1);
        send_request(bea_pkg::KIND_ALLOC, 9'h0aa);
        send_request(bea_pkg::KIND_FREE,  9'd255);
        send_request(bea_pkg::KIND_FREE,  9'd256);
        send_request(bea_pkg::KIND_FREE,  9'd511);
        send_request(bea_pkg::KIND_FREE,  9'd0);
        send_request(bea_pkg::KIND_ALLOC, 9'd0);
        settle();
        write_limit(0);
        send_request(bea_pkg::KIND_ALLOC, 9'd0);
        send_request(bea_pkg::KIND_FREE,  9'd0);
        send_request(bea_pkg::KIND_ALLOC, 9'd0);
        settle();
        write_limit(511);
        send_request(bea_pkg::KIND_ALLOC, 9'd0);
        send_request(bea_pkg::KIND_ALLOC, 9'd0);
        settle();
        write_limit(1);
        send_request(bea_pkg::KIND_ALLOC, 9'd0);
        send_request(bea_pkg::KIND_FREE,  9'd2);
        send_request(bea_pkg::KIND_ALLOC, 9'd0);

        // Random phases over limits and idling profiles
        run_phase(256, 90, 300,  0,  0, 1'b0);
        run_phase(511, 50, 250, 77,  0, 1'b0);
        run_phase(1,   60, 200,  0, 77, 1'b0);
        run_phase(8,   55, 250, 36, 36, 1'b0);
        run_phase(37,  70, 250,  0,  0, 1'b0);
        run_phase(300, 40, 250, 77,  0, 1'b0);
        run_phase($urandom_range(1, 256), 60, 250, 0, 77, 1'b0);
        run_phase(256, 85, 250, 36, 36, 1'b1);

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("[bitmap_entry_allocator] OK");
        end else begin
            $display("[bitmap_entry_allocator] ERROR");
        end
        $finish;
    end

endmodule
